// ===== src/rsi_pkg.sv =====
// Shared constants for the ray-sphere intersection pipeline.
// No dependencies; used by rsi_mul and ray_sphere_intersect.
`default_nettype none

package rsi_pkg;

    // Operand slice width of one partial product in the chunked multiplier
    localparam int MUL_CHUNK = 34;

    // Register stages through rsi_mul: magnitude, partial products, sum
    localparam int MUL_LATENCY = 3;

endpackage

`default_nettype wire

// ===== src/ray_sphere_intersect.sv =====
// Ray-sphere intersection: exact fixed-point quadratic solve, fully pipelined.
// Depends on rsi_pkg and rsi_mul.
//
// Usage:
//   s_axis carries one ray/sphere pair per word; m_axis returns one result word
//   (hit flag and nearest positive distance) per input word, in order.
//   Throughput: one word per cycle while the output is not stalled; every
//   stage is registered and an item enters each cycle the pipeline advances.
//   Depth: set by the bit-per-stage square root (2*COORD_WIDTH + FRAC_BITS
//   + 4 stages) and the bit-per-stage divider (COORD_WIDTH - 1 stages), plus
//   the two multiplier passes (3 stages each) and the single capture, sum,
//   c4, disc, numerator, saturation and output stages.
//   Stall: the whole pipeline advances together; while the output word is
//   held and not taken, s_axis_tready is low and every stage holds its word,
//   so nothing is lost or repeated. Bubbles travel as invalid words.
//   Reset: rst_n clears the valid bits only; no output appears until the
//   first accepted word has passed through.
//   Misses (zero direction, negative discriminant, no positive root) return
//   hit = 0 and distance 0. Distances saturate at the Q-format maximum.
`default_nettype none

module ray_sphere_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int IN_W  = ((10 * COORD_WIDTH - 1 + 7) / 8) * 8,
    localparam int OUT_W = ((COORD_WIDTH + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // ray_origin_x/y/z, ray_dir_x/y/z, sphere_center_x/y/z, sphere_diameter
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // hit, hit_distance
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int W     = COORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int ML    = rsi_pkg::MUL_LATENCY;
    localparam int A_W   = 2 * W + 2;
    localparam int H_W   = 2 * W + 3;
    localparam int LL_W  = 2 * W + 4;
    localparam int C_W   = 2 * W + 7;
    localparam int D_W   = 4 * W + 11;
    localparam int XW    = D_W - 1 + 2 * F - 2;
    localparam int RW    = (XW + 1) / 2;
    localparam int XPW   = 2 * RW;
    localparam int REM_W = RW + 3;
    localparam int HS_W  = H_W + F;
    localparam int N_W   = ((HS_W > RW) ? HS_W : RW) + 2;
    localparam int QW    = W - 1;
    localparam int DV_W  = ((N_W > A_W + QW) ? N_W : (A_W + QW)) + 1;
    localparam int LAT   = 7 + 2 * ML + RW + QW;

    typedef struct packed {
        logic           ok;
        logic           near;
        logic [A_W-1:0] a;
        logic [HS_W-1:0] hs;
    } sq_side_t;

    typedef struct packed {
        logic           ok;
        logic           sat;
        logic [A_W-1:0] a;
    } dv_side_t;

    logic             adv;
    logic [LAT-1:0]   valid_reg;

    // pipeline advance: output slot free or being taken
    assign adv           = !valid_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // input word unpack
    logic signed [W-1:0] in_coord [9];
    logic [W-2:0]        dia_in;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            in_coord[i] = s_axis_tdata[i*W +: W];
        end
        dia_in = s_axis_tdata[9*W +: W-1];
    end

    // stage 0: capture, l = origin - centre
    logic signed [W-1:0] d_reg [3];
    logic signed [W:0]   l_reg [3];
    logic signed [W-1:0] dia_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i] <= in_coord[3+i];
                l_reg[i] <= (W+1)'(in_coord[i]) - (W+1)'(in_coord[6+i]);
            end
            dia_reg <= $signed({1'b0, dia_in});
        end
    end

    // first multiplier pass: d.d, d.l, l.l terms and dia^2
    logic signed [2*W-1:0] p_aa [3];
    logic signed [2*W:0]   p_h  [3];
    logic signed [2*W+1:0] p_ll [3];
    logic signed [2*W-1:0] p_dd;

    for (genvar g = 0; g < 3; g++)
    begin : g_mul1
        rsi_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_aa (
            .clk(clk), .en(adv), .a(d_reg[g]), .b(d_reg[g]), .p(p_aa[g])
        );
        rsi_mul #(.A_WIDTH(W), .B_WIDTH(W+1)) u_h (
            .clk(clk), .en(adv), .a(d_reg[g]), .b(l_reg[g]), .p(p_h[g])
        );
        rsi_mul #(.A_WIDTH(W+1), .B_WIDTH(W+1)) u_ll (
            .clk(clk), .en(adv), .a(l_reg[g]), .b(l_reg[g]), .p(p_ll[g])
        );
    end

    rsi_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_dd (
        .clk(clk), .en(adv), .a(dia_reg), .b(dia_reg), .p(p_dd)
    );

    // dot product sums
    logic signed [A_W-1:0]  a4_reg;
    logic signed [H_W-1:0]  h4_reg;
    logic signed [LL_W-1:0] ll4_reg;
    logic signed [2*W-1:0]  dd4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a4_reg  <= A_W'(p_aa[0]) + A_W'(p_aa[1]) + A_W'(p_aa[2]);
            h4_reg  <= H_W'(p_h[0]) + H_W'(p_h[1]) + H_W'(p_h[2]);
            ll4_reg <= LL_W'(p_ll[0]) + LL_W'(p_ll[1]) + LL_W'(p_ll[2]);
            dd4_reg <= p_dd;
        end
    end

    // c4 = 4 l.l - dia^2
    logic signed [A_W-1:0] a5_reg;
    logic signed [H_W-1:0] h5_reg;
    logic signed [C_W-1:0] c5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a5_reg <= a4_reg;
            h5_reg <= h4_reg;
            c5_reg <= (C_W'(ll4_reg) <<< 2) - C_W'(dd4_reg);
        end
    end

    // second multiplier pass: h^2 and a*c4
    logic signed [2*H_W-1:0]   p_hh;
    logic signed [A_W+C_W-1:0] p_ac;

    rsi_mul #(.A_WIDTH(H_W), .B_WIDTH(H_W)) u_hh (
        .clk(clk), .en(adv), .a(h5_reg), .b(h5_reg), .p(p_hh)
    );
    rsi_mul #(.A_WIDTH(A_W), .B_WIDTH(C_W)) u_ac (
        .clk(clk), .en(adv), .a(a5_reg), .b(c5_reg), .p(p_ac)
    );

    // operands ride alongside the multiplier
    logic signed [A_W-1:0] a_d_reg [ML];
    logic signed [H_W-1:0] h_d_reg [ML];
    logic signed [C_W-1:0] c_d_reg [ML];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_d_reg[0] <= a5_reg;
            h_d_reg[0] <= h5_reg;
            c_d_reg[0] <= c5_reg;
            for (int i = 1; i < ML; i++)
            begin
                a_d_reg[i] <= a_d_reg[i-1];
                h_d_reg[i] <= h_d_reg[i-1];
                c_d_reg[i] <= c_d_reg[i-1];
            end
        end
    end

    // discriminant, root selection, sqrt operand
    logic signed [D_W-1:0] disc;
    logic                  near9;
    logic                  far9;
    logic                  ok9;
    logic [XPW-1:0]        x9_reg;
    sq_side_t              side9_reg;

    always_comb
    begin
        disc  = (D_W'(p_hh) <<< 2) - D_W'(p_ac);
        near9 = !c_d_reg[ML-1][C_W-1] && (c_d_reg[ML-1] != '0) && h_d_reg[ML-1][H_W-1];
        far9  = !near9 && (h_d_reg[ML-1][H_W-1] || c_d_reg[ML-1][C_W-1]);
        ok9   = (a_d_reg[ML-1] != '0) && !disc[D_W-1] && (near9 || far9);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x9_reg <= disc[D_W-1] ? '0 : (XPW'(disc[D_W-2:0]) << (2 * F - 2));
            side9_reg.ok   <= ok9;
            side9_reg.near <= near9;
            side9_reg.a    <= a_d_reg[ML-1];
            side9_reg.hs   <= HS_W'(h_d_reg[ML-1]) <<< F;
        end
    end

    // square root, one result bit a stage
    logic [REM_W-1:0] sq_rem_reg  [RW];
    logic [RW-1:0]    sq_root_reg [RW];
    logic [XPW-1:0]   sq_x_reg    [RW];
    sq_side_t         sq_side_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        logic [REM_W-1:0] rem_in;
        logic [REM_W-1:0] rem_t;
        logic [REM_W-1:0] trial;
        logic [RW-1:0]    root_in;
        logic [XPW-1:0]   x_in;
        sq_side_t         side_in;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = x9_reg;
            assign side_in = side9_reg;
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign x_in    = sq_x_reg[k-1];
            assign side_in = sq_side_reg[k-1];
        end

        always_comb
        begin
            rem_t = {rem_in[REM_W-3:0], x_in[XPW-1 -: 2]};
            trial = REM_W'({root_in, 2'b01});
            ge    = rem_t >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[k]  <= ge ? (rem_t - trial) : rem_t;
                sq_root_reg[k] <= {root_in[RW-2:0], ge};
                sq_x_reg[k]    <= x_in << 2;
                sq_side_reg[k] <= side_in;
            end
        end
    end

    // numerator: near root uses ceil(sqrt), far root floor(sqrt)
    logic signed [N_W-1:0] sf_n;
    logic signed [N_W-1:0] hs_n;
    logic                  inexact;
    logic [N_W-1:0]        n_reg;
    sq_side_t              side_n_reg;

    always_comb
    begin
        sf_n    = $signed(N_W'(sq_root_reg[RW-1]));
        hs_n    = N_W'($signed(sq_side_reg[RW-1].hs));
        inexact = sq_rem_reg[RW-1] != '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (sq_side_reg[RW-1].near)
            begin
                n_reg <= N_W'(-hs_n - sf_n - $signed(N_W'(inexact)));
            end
            else
            begin
                n_reg <= N_W'(sf_n - hs_n);
            end
            side_n_reg <= sq_side_reg[RW-1];
        end
    end

    // saturation check ahead of the divider
    logic [DV_W-1:0] ps_rem_reg;
    dv_side_t        ps_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ps_rem_reg      <= DV_W'(n_reg);
            ps_side_reg.ok  <= side_n_reg.ok;
            ps_side_reg.sat <= DV_W'(n_reg) >= (DV_W'(side_n_reg.a) << QW);
            ps_side_reg.a   <= side_n_reg.a;
        end
    end

    // restoring divide by a, one quotient bit a stage, msb first
    logic [DV_W-1:0] dv_rem_reg  [QW];
    logic [QW-1:0]   dv_q_reg    [QW];
    dv_side_t        dv_side_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [DV_W-1:0] rem_in;
        logic [QW-1:0]   q_in;
        dv_side_t        side_in;
        logic [DV_W-1:0] sh;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = ps_rem_reg;
            assign q_in    = '0;
            assign side_in = ps_side_reg;
        end
        else
        begin : g_next
            assign rem_in  = dv_rem_reg[k-1];
            assign q_in    = dv_q_reg[k-1];
            assign side_in = dv_side_reg[k-1];
        end

        always_comb
        begin
            sh = DV_W'(side_in.a) << (QW - 1 - k);
            ge = rem_in >= sh;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[k]  <= ge ? (rem_in - sh) : rem_in;
                dv_q_reg[k]    <= {q_in[QW-2:0], ge};
                dv_side_reg[k] <= side_in;
            end
        end
    end

    // output word
    logic          out_hit_reg;
    logic [QW-1:0] out_dist_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_hit_reg <= dv_side_reg[QW-1].ok;
            if (!dv_side_reg[QW-1].ok)
            begin
                out_dist_reg <= '0;
            end
            else if (dv_side_reg[QW-1].sat)
            begin
                out_dist_reg <= '1;
            end
            else
            begin
                out_dist_reg <= dv_q_reg[QW-1];
            end
        end
    end

    assign m_axis_tdata = OUT_W'({out_dist_reg, out_hit_reg});

endmodule

`default_nettype wire

// ===== src/rsi_mul.sv =====
// Pipelined signed multiplier built from chunk-sized partial products.
// Depends on rsi_pkg (MUL_CHUNK). Registered magnitude, chunk product and sum stages, advances on en.
`default_nettype none

module rsi_mul #(
    parameter int A_WIDTH = 32,
    parameter int B_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [A_WIDTH-1:0]         a,
    input  logic signed [B_WIDTH-1:0]         b,
    output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

    localparam int CH      = rsi_pkg::MUL_CHUNK;
    localparam int NA      = (A_WIDTH + CH - 1) / CH;
    localparam int NB      = (B_WIDTH + CH - 1) / CH;
    localparam int MA_W    = NA * CH;
    localparam int MB_W    = NB * CH;
    localparam int SUM_W   = (NA + NB) * CH;
    localparam int P_WIDTH = A_WIDTH + B_WIDTH;

    logic [A_WIDTH-1:0]      abs_a;
    logic [B_WIDTH-1:0]      abs_b;
    logic [MA_W-1:0]         mag_a_reg;
    logic [MB_W-1:0]         mag_b_reg;
    logic                    neg1_reg;
    logic [2*CH-1:0]         pp_reg [NA][NB];
    logic                    neg2_reg;
    logic [SUM_W-1:0]        acc;
    logic signed [P_WIDTH-1:0] p_next;
    logic signed [P_WIDTH-1:0] p_reg;

    // magnitudes; the most negative value maps onto its unsigned magnitude
    assign abs_a = a[A_WIDTH-1] ? A_WIDTH'(-a) : A_WIDTH'(a);
    assign abs_b = b[B_WIDTH-1] ? B_WIDTH'(-b) : B_WIDTH'(b);

    // stage 1: sign and magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg <= MA_W'(abs_a);
            mag_b_reg <= MB_W'(abs_b);
            neg1_reg  <= a[A_WIDTH-1] ^ b[B_WIDTH-1];
        end
    end

    // stage 2: chunk products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= (2*CH)'(mag_a_reg[i*CH +: CH]) *
                                    (2*CH)'(mag_b_reg[j*CH +: CH]);
                end
            end
            neg2_reg <= neg1_reg;
        end
    end

    // stage 3: align and sum partials, then apply sign
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (SUM_W'(pp_reg[i][j]) << (CH * (i + j)));
            end
        end
        p_next = neg2_reg ? -P_WIDTH'(acc) : P_WIDTH'(acc);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== src/rsi_check.sv =====
// Port-level checks for ray_sphere_intersect, attached by the bind below.
// Depends on ray_sphere_intersect's port list only.
`default_nettype none

module rsi_check #(
    parameter int COORD_WIDTH = 32,
    localparam int IN_W  = ((10 * COORD_WIDTH - 1 + 7) / 8) * 8,
    localparam int OUT_W = ((COORD_WIDTH + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // a held output word does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // an offered input word stays put until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input word changed while waiting");

    // pipeline takes input exactly when it can advance
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // a miss carries distance zero
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[COORD_WIDTH-1:1] == '0)
        else $error("miss with nonzero distance");

endmodule

bind ray_sphere_intersect rsi_check #(.COORD_WIDTH(COORD_WIDTH)) u_rsi_check (.*);

`default_nettype wire
